/* rtl/ahd_pkg.sv */
// Shared constants, word types and slot addressing for the hop distance block.
package ahd_pkg;

  localparam int MAX_VERTICES = 32;
  localparam int VW           = $clog2(MAX_VERTICES);
  localparam int STORE_DEPTH  = MAX_VERTICES * (MAX_VERTICES - 1) / 2;
  localparam int SW           = $clog2(STORE_DEPTH);
  localparam int DW           = 6;
  localparam int CW           = 6;
  localparam int HW           = 5;

  localparam logic [DW-1:0] DIST_INF = '1;
  localparam logic [DW-1:0] DIST_ONE = DW'(1);
  localparam logic [HW-1:0] HOP_MAX  = '1;

  typedef enum logic [1:0] {
    REQ_ADD     = 2'd0,
    REQ_REMOVE  = 2'd1,
    REQ_COMPUTE = 2'd2,
    REQ_QUERY   = 2'd3
  } req_kind_t;

  typedef struct packed {
    req_kind_t         req_type;
    logic [VW-1:0]     first_vertex;
    logic [VW-1:0]     second_vertex;
  } req_t;

  typedef struct packed {
    logic [HW-1:0] hop_distance;
    logic          unreachable;
    logic          bad_index;
    logic          compute_done;
  } rsp_t;

  // Pair (lo, hi), lo < hi, sits at MAX_VERTICES*lo + hi - (lo+1)(lo+2)/2.
  function automatic logic [SW-1:0] slot_addr(input logic [VW-1:0] a,
                                              input logic [VW-1:0] b);
    logic [VW-1:0]   lo;
    logic [VW-1:0]   hi;
    logic [2*VW:0]   base;
    logic [2*VW:0]   tri_n;
    logic [2*VW:0]   full;
    lo    = (a < b) ? a : b;
    hi    = (a < b) ? b : a;
    base  = (2*VW+1)'(lo) << VW;
    tri_n = (((2*VW+1)'(lo) + (2*VW+1)'(1)) * ((2*VW+1)'(lo) + (2*VW+1)'(2))) >> 1;
    full  = base + (2*VW+1)'(hi) - tri_n;
    return full[SW-1:0];
  endfunction

endpackage

/* rtl/all_pairs_hop_distance.sv */
// Top level: adjacency and distance memories with the edit, query and relaxation sequencer.
//
//  channel   ports                          handshake
//  --------  -----------------------------  ---------------------------------
//  request   start, busy, in_word           word taken when start & !busy
//  result    out_valid, out_word            one-cycle strobe, cannot stall
//  config    cfg_we, cfg_wdata              written when cfg_we is high
//
// An add or remove steps through S_EDGE_A and S_EDGE_B and a query through S_QUERY;
// a bad vertex, a self-loop or a query of a vertex with itself is answered from idle.
// A compute first reseeds all 496 store entries, then relaxes with one
// read/compare/write step per pair through the two-read-port distance memory.
// Reset is synchronous; the distance store needs no clearing pass since queries
// read as infinity until the first compute rewrites every entry.
module all_pairs_hop_distance import ahd_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  req_t          in_word,
  output logic          out_valid,
  output rsp_t          out_word,
  input  logic          cfg_we,
  input  logic [CW-1:0] cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EDGE_A,
    S_EDGE_B,
    S_QUERY,
    S_SEED_RD,
    S_SEED_WR,
    S_ROW_RD,
    S_ROW_LD,
    S_RELAX_RD,
    S_RELAX_WR
  } state_t;

  logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
  logic [DW-1:0]           dist_mem [STORE_DEPTH];

  state_t                  state_r;
  logic [CW-1:0]           vcount_r;
  logic                    store_vld_r;
  logic [MAX_VERTICES-1:0] adj_vld_r;
  req_t                    op_r;
  logic [VW-1:0]           i_r;
  logic [VW-1:0]           j_r;
  logic [VW-1:0]           k_r;
  logic [SW-1:0]           seed_addr_r;
  logic [DW-1:0]           dik_r;
  logic                    out_valid_r;
  rsp_t                    out_word_r;

  logic [MAX_VERTICES-1:0] adj_q;
  logic [DW-1:0]           dist_a_q;
  logic [DW-1:0]           dist_b_q;

  logic [VW-1:0]           n_m1;
  logic                    accept;
  logic                    in_bad;
  logic [VW-1:0]           adj_raddr;
  logic                    adj_we;
  logic [VW-1:0]           adj_waddr;
  logic [MAX_VERTICES-1:0] adj_wdata;
  logic                    edge_bit;
  logic [SW-1:0]           dist_raddr_a;
  logic [SW-1:0]           dist_raddr_b;
  logic                    dist_we;
  logic [SW-1:0]           dist_waddr;
  logic [DW-1:0]           dist_wdata;
  logic [DW:0]             relax_sum;
  logic [DW-1:0]           relax_sat;
  logic                    relax_wr;
  logic [DW-1:0]           query_d;
  logic                    row_last;
  logic                    k_last;

  // Effective vertex count saturates to 1..MAX_VERTICES; kept as count minus one.
  always_comb begin
    if (vcount_r == '0) begin
      n_m1 = '0;
    end else if (vcount_r > CW'(MAX_VERTICES)) begin
      n_m1 = VW'(MAX_VERTICES - 1);
    end else begin
      n_m1 = VW'(vcount_r - CW'(1));
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign in_bad    = (in_word.first_vertex > n_m1) || (in_word.second_vertex > n_m1);
  assign edge_bit  = (op_r.req_type == REQ_ADD);
  assign row_last  = (i_r == n_m1 - VW'(1));
  assign k_last    = (k_r == n_m1);

  assign relax_sum = {1'b0, dik_r} + {1'b0, dist_a_q};
  assign relax_sat = (relax_sum > {1'b0, DIST_INF}) ? DIST_INF : relax_sum[DW-1:0];
  assign relax_wr  = (j_r != k_r) && (relax_sat < dist_b_q);
  assign query_d   = store_vld_r ? dist_a_q : DIST_INF;

  // Memory address and write control follow the sequencer state.
  always_comb begin
    adj_raddr    = i_r;
    adj_we       = 1'b0;
    adj_waddr    = op_r.first_vertex;
    adj_wdata    = adj_q;
    dist_raddr_a = slot_addr(k_r, j_r);
    dist_raddr_b = slot_addr(i_r, j_r);
    dist_we      = 1'b0;
    dist_waddr   = slot_addr(i_r, j_r);
    dist_wdata   = relax_sat;
    case (state_r)
      S_IDLE: begin
        adj_raddr    = in_word.first_vertex;
        dist_raddr_a = slot_addr(in_word.first_vertex, in_word.second_vertex);
      end
      S_EDGE_A: begin
        adj_raddr                      = op_r.second_vertex;
        adj_we                         = 1'b1;
        adj_waddr                      = op_r.first_vertex;
        adj_wdata[op_r.second_vertex]  = edge_bit;
      end
      S_EDGE_B: begin
        adj_we                         = 1'b1;
        adj_waddr                      = op_r.second_vertex;
        adj_wdata[op_r.first_vertex]   = edge_bit;
      end
      S_SEED_WR: begin
        dist_we    = 1'b1;
        dist_waddr = seed_addr_r;
        dist_wdata = ((j_r <= n_m1) && adj_q[j_r]) ? DIST_ONE : DIST_INF;
      end
      S_ROW_RD: begin
        dist_raddr_a = slot_addr(i_r, k_r);
      end
      S_RELAX_WR: begin
        dist_we = relax_wr;
      end
      default: begin
      end
    endcase
  end

  // Adjacency rows read as zero until first written.
  always_ff @(posedge clk) begin
    if (adj_we) begin
      adj_mem[adj_waddr] <= adj_wdata;
    end
    adj_q <= adj_vld_r[adj_raddr] ? adj_mem[adj_raddr] : '0;
  end

  always_ff @(posedge clk) begin
    if (dist_we) begin
      dist_mem[dist_waddr] <= dist_wdata;
    end
    dist_a_q <= dist_mem[dist_raddr_a];
    dist_b_q <= dist_mem[dist_raddr_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vcount_r    <= CW'(MAX_VERTICES);
      store_vld_r <= 1'b0;
      adj_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        vcount_r <= cfg_wdata;
      end
      if (adj_we) begin
        adj_vld_r[adj_waddr] <= 1'b1;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            op_r       <= in_word;
            out_word_r <= '0;
            if (in_word.req_type == REQ_COMPUTE) begin
              store_vld_r <= 1'b1;
              seed_addr_r <= '0;
              i_r         <= '0;
              state_r     <= S_SEED_RD;
            end else if (in_bad) begin
              out_valid_r          <= 1'b1;
              out_word_r.bad_index <= 1'b1;
            end else if (in_word.first_vertex == in_word.second_vertex) begin
              out_valid_r <= 1'b1;
            end else if (in_word.req_type == REQ_QUERY) begin
              state_r <= S_QUERY;
            end else begin
              state_r <= S_EDGE_A;
            end
          end
        end
        S_EDGE_A: begin
          state_r <= S_EDGE_B;
        end
        S_EDGE_B: begin
          out_valid_r <= 1'b1;
          out_word_r  <= '0;
          state_r     <= S_IDLE;
        end
        S_QUERY: begin
          out_valid_r              <= 1'b1;
          out_word_r               <= '0;
          out_word_r.unreachable   <= (query_d == DIST_INF);
          if (query_d != DIST_INF) begin
            out_word_r.hop_distance <= (query_d > DW'(HOP_MAX)) ? HOP_MAX
                                                                : query_d[HW-1:0];
          end
          state_r <= S_IDLE;
        end
        S_SEED_RD: begin
          j_r     <= i_r + VW'(1);
          state_r <= S_SEED_WR;
        end
        S_SEED_WR: begin
          seed_addr_r <= seed_addr_r + SW'(1);
          if (j_r == VW'(MAX_VERTICES - 1)) begin
            if (i_r == VW'(MAX_VERTICES - 2)) begin
              if (n_m1 == '0) begin
                out_valid_r             <= 1'b1;
                out_word_r              <= '0;
                out_word_r.compute_done <= 1'b1;
                state_r                 <= S_IDLE;
              end else begin
                k_r     <= '0;
                i_r     <= '0;
                state_r <= S_ROW_RD;
              end
            end else begin
              i_r     <= i_r + VW'(1);
              state_r <= S_SEED_RD;
            end
          end else begin
            j_r <= j_r + VW'(1);
          end
        end
        S_ROW_RD: begin
          j_r <= i_r + VW'(1);
          if (i_r != k_r) begin
            state_r <= S_ROW_LD;
          end else if (!row_last) begin
            i_r <= i_r + VW'(1);
          end else if (!k_last) begin
            k_r <= k_r + VW'(1);
            i_r <= '0;
          end else begin
            out_valid_r             <= 1'b1;
            out_word_r              <= '0;
            out_word_r.compute_done <= 1'b1;
            state_r                 <= S_IDLE;
          end
        end
        S_ROW_LD: begin
          dik_r   <= dist_a_q;
          state_r <= S_RELAX_RD;
        end
        S_RELAX_RD: begin
          state_r <= S_RELAX_WR;
        end
        S_RELAX_WR: begin
          if (j_r != n_m1) begin
            j_r     <= j_r + VW'(1);
            state_r <= S_RELAX_RD;
          end else if (!row_last) begin
            i_r     <= i_r + VW'(1);
            state_r <= S_ROW_RD;
          end else if (!k_last) begin
            k_r     <= k_r + VW'(1);
            i_r     <= '0;
            state_r <= S_ROW_RD;
          end else begin
            out_valid_r             <= 1'b1;
            out_word_r              <= '0;
            out_word_r.compute_done <= 1'b1;
            state_r                 <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

/* rtl/ahd_checker.sv */
// Port-level checker for the hop distance block, bound to the top level.
module ahd_checker import ahd_pkg::*; (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input req_t          in_word,
  input logic          out_valid,
  input rsp_t          out_word
);

  // A result word only follows an accepted word or ongoing work.
  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(start && !busy) || $past(busy)))
    else $error("result word without an accepted request");

  // Leaving the busy state always delivers the result word.
  a_busy_ends_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result word");

  a_compute_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_word.req_type == REQ_COMPUTE)) |=> busy)
    else $error("compute request did not start the sequencer");

  // The status flags of a result word exclude one another.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($countones({out_word.unreachable, out_word.bad_index,
                               out_word.compute_done}) <= 1))
    else $error("more than one status flag in a result word");

  a_flag_zero_hops: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_word.unreachable || out_word.bad_index || out_word.compute_done))
      |-> (out_word.hop_distance == '0))
    else $error("flagged result word carries a hop count");

endmodule

bind all_pairs_hop_distance ahd_checker u_ahd_checker (.*);
